>>> rtl/bqd_pkg.sv
`default_nettype none

package bqd_pkg;

	localparam int COEF_W     = 32;
	localparam int NUM_COEF   = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int ACC_W      = 48;
	localparam int GUARD_FRAC = 8;
	localparam int Y_SPLIT    = 24;
	localparam int MUL_A_W    = 33;
	localparam int MUL_P_W    = MUL_A_W + COEF_W;
	localparam int PROD_W     = 80;
	localparam int SUM_W      = ACC_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_FEED0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEED1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEED2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACK1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BACK2 = 3'd4;

	localparam logic [COEF_W-1:0] FEED0_RESET = 32'd268435456;

	localparam logic signed [PROD_W-1:0] ACC_MAX_EXT =
		signed'({{(PROD_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}});
	localparam logic signed [PROD_W-1:0] ACC_MIN_EXT = ~ACC_MAX_EXT;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_RND,
		ST_SUM,
		ST_FIN,
		ST_DONE
	} state_t;

	// product terms in evaluation order
	typedef enum logic [2:0] {
		TERM_B0X,
		TERM_B1X,
		TERM_A1Y,
		TERM_B2X,
		TERM_A2Y
	} term_t;

	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic acc_first;
		logic acc_hi;
		logic rnd_en;
		logic y_scale;
	} prod_ctrl_t;

	function automatic logic term_uses_y(input term_t t);
		return (t == TERM_A1Y) || (t == TERM_A2Y);
	endfunction

	function automatic logic term_closes(input term_t t);
		return (t == TERM_B0X) || (t == TERM_A1Y) || (t == TERM_A2Y);
	endfunction

	function automatic logic [CFG_IDX_W-1:0] term_coef(input term_t t);
		logic [CFG_IDX_W-1:0] idx;
		case (t)
			TERM_B0X: idx = REG_FEED0;
			TERM_B1X: idx = REG_FEED1;
			TERM_A1Y: idx = REG_BACK1;
			TERM_B2X: idx = REG_FEED2;
			TERM_A2Y: idx = REG_BACK2;
			default:  idx = REG_FEED0;
		endcase
		return idx;
	endfunction

	function automatic term_t term_next(input term_t t);
		term_t n;
		case (t)
			TERM_B0X: n = TERM_B1X;
			TERM_B1X: n = TERM_A1Y;
			TERM_A1Y: n = TERM_B2X;
			TERM_B2X: n = TERM_A2Y;
			default:  n = TERM_B0X;
		endcase
		return n;
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [PROD_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		if (v > ACC_MAX_EXT) begin
			r = ACC_MAX_EXT[ACC_W-1:0];
		end else if (v < ACC_MIN_EXT) begin
			r = ACC_MIN_EXT[ACC_W-1:0];
		end else begin
			r = v[ACC_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/biquad_iir_filter_unit.sv
`default_nettype none

// Transposed direct form II biquad, one sample at a time: a new sample is not taken
// until the last one is done. A single 33x32 multiplier is shared by the five coefficient
// products (the two feedback products on the 48-bit output take two passes each), each
// followed by accumulate, round and sum steps. in_ready is high only between samples; a
// finished result waits in the output register while the next sample is processed.
// Coefficients are signed Q3.28 and may be written at any register index 0..4 while idle.
module biquad_iir_filter_unit #(
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 28
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [bqd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [bqd_pkg::COEF_W-1:0]           cfg_data,
	input  wire                                       in_valid,
	output logic                                      in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]        sample_in,
	output logic                                      out_valid,
	input  wire                                       out_ready,
	output logic signed [SAMPLE_BITS-1:0]             sample_out,
	output logic                                      clipped
);

	localparam int Q_W = bqd_pkg::ACC_W - bqd_pkg::GUARD_FRAC + 1;
	localparam logic signed [Q_W-1:0] SMAX =
		signed'({{(Q_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
	localparam logic signed [Q_W-1:0] SMIN = ~SMAX;
	localparam logic signed [bqd_pkg::ACC_W:0] OUT_HALF =
		signed'((bqd_pkg::ACC_W+1)'(1) << (bqd_pkg::GUARD_FRAC - 1));

	bqd_pkg::state_t     state_q, state_d;
	bqd_pkg::term_t      term_q;
	bqd_pkg::prod_ctrl_t ctrl;
	logic                pp_q;
	logic                out_load;
	logic                out_valid_q;

	logic [bqd_pkg::COEF_W-1:0]            coef_q [bqd_pkg::NUM_COEF];
	logic signed [SAMPLE_BITS-1:0]         x_q;
	logic signed [bqd_pkg::ACC_W-1:0]      y_q, s1_q, s2_q;
	logic signed [bqd_pkg::SUM_W-1:0]      sum_q;
	logic signed [SAMPLE_BITS-1:0]         sample_q;
	logic                                  clip_q;

	logic signed [bqd_pkg::MUL_A_W-1:0]    op_a;
	logic signed [bqd_pkg::COEF_W-1:0]     op_b;
	logic signed [bqd_pkg::PROD_W-1:0]     prod_res;
	logic signed [bqd_pkg::ACC_W-1:0]      term_sat;
	logic signed [bqd_pkg::SUM_W-1:0]      term_ext;
	logic signed [bqd_pkg::ACC_W-1:0]      fin_word;
	logic signed [bqd_pkg::ACC_W:0]        y_round;
	logic signed [Q_W-1:0]                 q_val;
	logic                                  uses_y;

	bqd_prod_unit #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_prod (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.op_a  (op_a),
		.op_b  (op_b),
		.result(prod_res)
	);

	always_comb begin
		uses_y = bqd_pkg::term_uses_y(term_q);
		if (!uses_y) begin
			op_a = {{(bqd_pkg::MUL_A_W-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
		end else if (pp_q) begin
			op_a = {{(bqd_pkg::MUL_A_W-(bqd_pkg::ACC_W-bqd_pkg::Y_SPLIT)){y_q[bqd_pkg::ACC_W-1]}},
				y_q[bqd_pkg::ACC_W-1:bqd_pkg::Y_SPLIT]};
		end else begin
			op_a = {{(bqd_pkg::MUL_A_W-bqd_pkg::Y_SPLIT){1'b0}}, y_q[bqd_pkg::Y_SPLIT-1:0]};
		end
		op_b = coef_q[bqd_pkg::term_coef(term_q)];

		term_sat = bqd_pkg::sat_acc(prod_res);
		term_ext = {{(bqd_pkg::SUM_W-bqd_pkg::ACC_W){term_sat[bqd_pkg::ACC_W-1]}}, term_sat};
		fin_word = bqd_pkg::sat_acc({{(bqd_pkg::PROD_W-bqd_pkg::SUM_W){sum_q[bqd_pkg::SUM_W-1]}},
			sum_q});

		// add half then floor
		y_round = {y_q[bqd_pkg::ACC_W-1], y_q} + OUT_HALF;
		q_val   = y_round[bqd_pkg::ACC_W:bqd_pkg::GUARD_FRAC];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bqd_pkg::ST_IDLE: if (in_valid) state_d = bqd_pkg::ST_MUL;
			bqd_pkg::ST_MUL:  state_d = bqd_pkg::ST_ACC;
			bqd_pkg::ST_ACC:  state_d = (uses_y && !pp_q) ? bqd_pkg::ST_MUL : bqd_pkg::ST_RND;
			bqd_pkg::ST_RND:  state_d = bqd_pkg::ST_SUM;
			bqd_pkg::ST_SUM: begin
				state_d = bqd_pkg::term_closes(term_q) ? bqd_pkg::ST_FIN : bqd_pkg::ST_MUL;
			end
			bqd_pkg::ST_FIN: begin
				state_d = (term_q == bqd_pkg::TERM_A2Y) ? bqd_pkg::ST_DONE : bqd_pkg::ST_MUL;
			end
			bqd_pkg::ST_DONE: if (out_load) state_d = bqd_pkg::ST_IDLE;
			default:          state_d = bqd_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctrl     = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			bqd_pkg::ST_IDLE: in_ready = 1'b1;
			bqd_pkg::ST_MUL:  ctrl.mul_en = 1'b1;
			bqd_pkg::ST_ACC: begin
				ctrl.acc_en    = 1'b1;
				ctrl.acc_first = !pp_q;
				ctrl.acc_hi    = pp_q;
			end
			bqd_pkg::ST_RND: begin
				ctrl.rnd_en  = 1'b1;
				ctrl.y_scale = uses_y;
			end
			bqd_pkg::ST_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bqd_pkg::ST_IDLE;
			term_q      <= bqd_pkg::TERM_B0X;
			pp_q        <= 1'b0;
			out_valid_q <= 1'b0;
			s1_q        <= '0;
			s2_q        <= '0;
			coef_q[0]   <= bqd_pkg::FEED0_RESET;
			for (int i = 1; i < bqd_pkg::NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_valid && (cfg_index < bqd_pkg::CFG_IDX_W'(bqd_pkg::NUM_COEF))) begin
				coef_q[cfg_index] <= cfg_data;
			end

			case (state_q)
				bqd_pkg::ST_IDLE: begin
					if (in_valid) begin
						term_q <= bqd_pkg::TERM_B0X;
						pp_q   <= 1'b0;
					end
				end
				bqd_pkg::ST_ACC: if (uses_y && !pp_q) pp_q <= 1'b1;
				bqd_pkg::ST_SUM: begin
					if (!bqd_pkg::term_closes(term_q)) begin
						term_q <= bqd_pkg::term_next(term_q);
						pp_q   <= 1'b0;
					end
				end
				bqd_pkg::ST_FIN: begin
					case (term_q)
						bqd_pkg::TERM_A1Y: s1_q <= fin_word;
						bqd_pkg::TERM_A2Y: s2_q <= fin_word;
						default: ;
					endcase
					if (term_q != bqd_pkg::TERM_A2Y) begin
						term_q <= bqd_pkg::term_next(term_q);
						pp_q   <= 1'b0;
					end
				end
				default: ;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		case (state_q)
			bqd_pkg::ST_IDLE: begin
				if (in_valid) begin
					x_q   <= sample_in;
					sum_q <= {{(bqd_pkg::SUM_W-bqd_pkg::ACC_W){s1_q[bqd_pkg::ACC_W-1]}}, s1_q};
				end
			end
			bqd_pkg::ST_SUM: begin
				sum_q <= uses_y ? sum_q - term_ext : sum_q + term_ext;
			end
			bqd_pkg::ST_FIN: begin
				case (term_q)
					bqd_pkg::TERM_B0X: begin
						y_q   <= fin_word;
						sum_q <= {{(bqd_pkg::SUM_W-bqd_pkg::ACC_W){s2_q[bqd_pkg::ACC_W-1]}}, s2_q};
					end
					bqd_pkg::TERM_A1Y: sum_q <= '0;
					default: ;
				endcase
			end
			default: ;
		endcase

		if (out_load) begin
			if (q_val > SMAX) begin
				sample_q <= SMAX[SAMPLE_BITS-1:0];
				clip_q   <= 1'b1;
			end else if (q_val < SMIN) begin
				sample_q <= SMIN[SAMPLE_BITS-1:0];
				clip_q   <= 1'b1;
			end else begin
				sample_q <= q_val[SAMPLE_BITS-1:0];
				clip_q   <= 1'b0;
			end
		end
	end

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;
	assign clipped    = clip_q;

endmodule

`default_nettype wire

>>> rtl/bqd_prod_unit.sv
`default_nettype none

module bqd_prod_unit #(
	parameter int COEF_FRAC_BITS = 28
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire bqd_pkg::prod_ctrl_t                ctrl,
	input  wire logic signed [bqd_pkg::MUL_A_W-1:0] op_a,
	input  wire logic signed [bqd_pkg::COEF_W-1:0]  op_b,
	output logic signed [bqd_pkg::PROD_W-1:0]       result
);

	localparam int XSH = COEF_FRAC_BITS - bqd_pkg::GUARD_FRAC;
	localparam int YSH = COEF_FRAC_BITS;
	localparam logic signed [bqd_pkg::PROD_W-1:0] HALF_X =
		signed'(bqd_pkg::PROD_W'(1) << (XSH - 1));
	localparam logic signed [bqd_pkg::PROD_W-1:0] HALF_Y =
		signed'(bqd_pkg::PROD_W'(1) << (YSH - 1));

	logic signed [bqd_pkg::MUL_P_W-1:0] mul_q;
	logic signed [bqd_pkg::PROD_W-1:0]  prod_q;
	logic signed [bqd_pkg::PROD_W-1:0]  res_q;
	logic signed [bqd_pkg::PROD_W-1:0]  pp_ext;
	logic signed [bqd_pkg::PROD_W-1:0]  pp_shift;
	logic signed [bqd_pkg::PROD_W-1:0]  neg_corr;
	logic signed [bqd_pkg::PROD_W-1:0]  rnd_x;
	logic signed [bqd_pkg::PROD_W-1:0]  rnd_y;

	always_comb begin
		pp_ext   = {{(bqd_pkg::PROD_W-bqd_pkg::MUL_P_W){mul_q[bqd_pkg::MUL_P_W-1]}}, mul_q};
		pp_shift = ctrl.acc_hi ? (pp_ext <<< bqd_pkg::Y_SPLIT) : pp_ext;
		// ties away from zero: negative products round with half minus one
		neg_corr = {{(bqd_pkg::PROD_W-1){1'b0}}, prod_q[bqd_pkg::PROD_W-1]};
		rnd_x    = prod_q + HALF_X - neg_corr;
		rnd_y    = prod_q + HALF_Y - neg_corr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= '0;
			prod_q <= '0;
			res_q  <= '0;
		end else begin
			if (ctrl.mul_en) begin
				mul_q <= op_a * op_b;
			end
			if (ctrl.acc_en) begin
				prod_q <= ctrl.acc_first ? pp_shift : prod_q + pp_shift;
			end
			if (ctrl.rnd_en) begin
				res_q <= ctrl.y_scale ? (rnd_y >>> YSH) : (rnd_x >>> XSH);
			end
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import bqd_pkg::*;

	localparam int SMP_W       = 24;
	localparam int COEF_FRAC   = 28;
	localparam int XSH         = COEF_FRAC - GUARD_FRAC;
	localparam int YSH         = COEF_FRAC;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 190;
	localparam int RAND_PHASES = 10;

	typedef logic signed [SMP_W-1:0]  sample_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct {
		sample_t sample;
		logic    clip;
	} filt_result_t;

	typedef enum {PAT_NOISE, PAT_QUIET, PAT_STEP, PAT_IMPULSE, PAT_NYQUIST} pattern_t;
	typedef enum {STYLE_STABLE, STYLE_WILD, STYLE_CORNER} coef_style_t;

	localparam sample_t SMP_MAX    = {1'b0, {(SMP_W-1){1'b1}}};
	localparam sample_t SMP_MIN    = ~SMP_MAX;
	localparam longint  SMP_TOP    = (longint'(1) << (SMP_W-1)) - 1;
	localparam longint  SMP_BOT    = -SMP_TOP - 1;
	localparam longint  ACC_TOP    = (longint'(1) << (ACC_W-1)) - 1;
	localparam longint  ACC_BOT    = -ACC_TOP - 1;
	localparam longint  ROUND_HALF = longint'(1) << (GUARD_FRAC-1);
	localparam coef_t   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
	localparam coef_t   COEF_MIN   = ~COEF_MAX;
	localparam coef_t   COEF_UNITY = coef_t'(FEED0_RESET);
	localparam coef_t   COEF_HALF  = COEF_UNITY >>> 1;
	localparam coef_t   COEF_XTIE  = coef_t'(1) <<< (XSH-1);

	class biquad_scoreboard;
		coef_t        coef[NUM_COEF];
		longint       delay1;
		longint       delay2;
		filt_result_t due_outputs[$];
		int           errors;

		function new();
			foreach (coef[i]) coef[i] = '0;
			coef[REG_FEED0] = COEF_UNITY;
			delay1 = 0;
			delay2 = 0;
			errors = 0;
		endfunction

		function void load_coef(logic [CFG_IDX_W-1:0] idx, coef_t v);
			if (idx < NUM_COEF) coef[idx] = v;
		endfunction

		function longint clamp_acc(longint v);
			if (v > ACC_TOP) return ACC_TOP;
			if (v < ACC_BOT) return ACC_BOT;
			return v;
		endfunction

		// a*c / 2^sh, nearest with ties away from zero, clamped to the state width
		function longint scaled_product(longint a, longint c, int sh);
			logic [127:0] ma;
			logic [127:0] mc;
			logic [127:0] mag;
			ma = (a < 0) ? 128'(-a) : 128'(a);
			mc = (c < 0) ? 128'(-c) : 128'(c);
			mag = (ma * mc + (128'd1 << (sh-1))) >> sh;
			if ((a < 0) != (c < 0))
				return (mag > (128'd1 << (ACC_W-1))) ? ACC_BOT : -longint'(mag);
			return (mag > 128'(ACC_TOP)) ? ACC_TOP : longint'(mag);
		endfunction

		function void take_sample(sample_t x);
			longint       xv;
			longint       y;
			longint       q;
			filt_result_t r;
			xv = x;
			y = clamp_acc(scaled_product(xv, coef[REG_FEED0], XSH) + delay1);
			delay1 = clamp_acc(scaled_product(xv, coef[REG_FEED1], XSH)
				- scaled_product(y, coef[REG_BACK1], YSH) + delay2);
			delay2 = clamp_acc(scaled_product(xv, coef[REG_FEED2], XSH)
				- scaled_product(y, coef[REG_BACK2], YSH));
			q = (y + ROUND_HALF) >>> GUARD_FRAC;
			r.clip = 1'b0;
			if (q > SMP_TOP) begin
				q = SMP_TOP;
				r.clip = 1'b1;
			end
			if (q < SMP_BOT) begin
				q = SMP_BOT;
				r.clip = 1'b1;
			end
			r.sample = sample_t'(q);
			due_outputs.push_back(r);
		endfunction

		function void check_output(sample_t got, logic got_clip);
			filt_result_t want;
			if (due_outputs.size() == 0) begin
				errors++;
				$display("%0t: output with none due: expected nothing, got sample_out=%0d clipped=%0b",
					$time, got, got_clip);
				return;
			end
			want = due_outputs.pop_front();
			if (got !== want.sample) begin
				errors++;
				$display("%0t: sample_out expected %0d, got %0d", $time, want.sample, got);
			end
			if (got_clip !== want.clip) begin
				errors++;
				$display("%0t: clipped expected %0b, got %0b", $time, want.clip, got_clip);
			end
		endfunction

		function int pending();
			return due_outputs.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [COEF_W-1:0]       cfg_data  = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	sample_t                 sample_in = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	sample_t                 sample_out;
	logic                    clipped;

	biquad_scoreboard sb;
	bit               steady = 1'b0;
	int               stall_left = 0;
	int               idle_cycles = 0;

	biquad_iir_filter_unit #(
		.SAMPLE_BITS   (SMP_W),
		.COEF_FRAC_BITS(COEF_FRAC)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out),
		.clipped   (clipped)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver back-pressure: short random gaps plus the odd long stall, none while steady
	always @(posedge clk) begin
		if (steady) begin
			out_ready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(999) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(80, 1);
		end else begin
			out_ready <= ($urandom_range(99) >= 32);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_output(sample_out, clipped);
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input coef_t v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.load_coef(idx, v);
	endtask

	task automatic program_filter(input coef_t b0, b1, b2, a1, a2);
		cfg_write(REG_FEED0, b0);
		cfg_write(REG_FEED1, b1);
		cfg_write(REG_FEED2, b2);
		cfg_write(REG_BACK1, a1);
		cfg_write(REG_BACK2, a2);
		if ($urandom_range(3) == 0)
			cfg_write(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, NUM_COEF)), coef_t'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic push_sample(input sample_t x);
		if (!steady && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(60, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= x;
		do @(posedge clk); while (!in_ready);
		sb.take_sample(x);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic program_random(input coef_style_t style);
		coef_t  c[NUM_COEF];
		coef_t  corner_coefs[5];
		longint a2;
		longint lim;
		corner_coefs = '{COEF_MAX, COEF_MIN, '0, COEF_UNITY, -COEF_UNITY};
		case (style)
			STYLE_STABLE: begin
				// poles kept inside the unit circle
				a2 = $urandom_range(255000000);
				lim = ((longint'(COEF_UNITY) + a2) * 95) / 100;
				c[REG_BACK2] = coef_t'(a2);
				c[REG_BACK1] = coef_t'($urandom_range(lim));
				if ($urandom_range(1)) c[REG_BACK1] = -c[REG_BACK1];
				c[REG_FEED0] = coef_t'(int'($urandom_range(2 * COEF_UNITY)) - int'(COEF_UNITY));
				c[REG_FEED1] = coef_t'(int'($urandom_range(2 * COEF_UNITY)) - int'(COEF_UNITY));
				c[REG_FEED2] = coef_t'(int'($urandom_range(2 * COEF_UNITY)) - int'(COEF_UNITY));
			end
			STYLE_WILD: begin
				foreach (c[i]) c[i] = coef_t'($urandom);
			end
			default: begin
				foreach (c[i]) c[i] = corner_coefs[$urandom_range($size(corner_coefs) - 1)];
			end
		endcase
		program_filter(c[REG_FEED0], c[REG_FEED1], c[REG_FEED2], c[REG_BACK1], c[REG_BACK2]);
	endtask

	task automatic play_random(input int count);
		pattern_t pat;
		int       run;
		int       left;
		sample_t  hold;
		left = count;
		while (left > 0) begin
			pat = pattern_t'($urandom_range(PAT_NYQUIST));
			run = $urandom_range(32, 1);
			if (run > left) run = left;
			if ($urandom_range(3) == 0) hold = $urandom_range(1) ? SMP_MAX : SMP_MIN;
			else hold = sample_t'($urandom);
			for (int k = 0; k < run; k++) begin
				case (pat)
					PAT_NOISE:   push_sample(sample_t'($urandom));
					PAT_QUIET:   push_sample(sample_t'(int'($urandom_range(4095)) - 2048));
					PAT_STEP:    push_sample(hold);
					PAT_IMPULSE: push_sample((k == 0) ? hold : sample_t'(0));
					default:     push_sample(k[0] ? -hold : hold);
				endcase
			end
			left -= run;
		end
	endtask

	initial begin
		sample_t pass_set[7];
		sample_t half_set[6];
		sample_t tie_set[4];
		sample_t tie_after[2];
		sample_t top_set[4];
		sample_t bot_set[3];

		pass_set  = '{0, 1, -1, SMP_MAX, SMP_MIN, 24'sh555555, 24'shAAAAAA};
		half_set  = '{1, -1, 3, -3, SMP_MAX, SMP_MIN};
		tie_set   = '{1, -1, 5, -5};
		tie_after = '{7, -7};
		top_set   = '{SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN};
		bot_set   = '{SMP_MAX, SMP_MIN, 1};

		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// coefficients as left by reset: straight pass-through
		foreach (pass_set[i]) push_sample(pass_set[i]);
		wait_drained();

		// half gain: odd inputs land exactly between two output codes
		program_filter(COEF_HALF, '0, '0, '0, '0);
		foreach (half_set[i]) push_sample(half_set[i]);
		wait_drained();

		// product ties on both coefficient signs, then writes to unused indices
		program_filter(COEF_XTIE, -COEF_XTIE, COEF_XTIE, '0, '0);
		foreach (tie_set[i]) push_sample(tie_set[i]);
		wait_drained();
		for (int i = NUM_COEF; i < (1 << CFG_IDX_W); i++)
			cfg_write(CFG_IDX_W'(i), coef_t'($urandom));
		cfg_valid <= 1'b0;
		foreach (tie_after[i]) push_sample(tie_after[i]);
		wait_drained();

		// coefficient extremes drive products, states and output into saturation
		program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		foreach (top_set[i]) push_sample(top_set[i]);
		wait_drained();
		program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
		foreach (bot_set[i]) push_sample(bot_set[i]);
		wait_drained();

		for (int p = 0; p < RAND_PHASES; p++) begin
			program_random(coef_style_t'(p % 3));
			steady = (p == 4);
			play_random(PHASE_ITEMS);
			wait_drained();
			steady = 1'b0;
		end

		repeat (40) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
